### rtl/cqs_pkg.sv
// Shared constants for the circular queue with search.
package cqs_pkg;

  localparam int WORD_W    = 32;
  localparam int CAP_W     = 9;
  localparam int SLOT_W    = 8;
  localparam int KIND_W    = 2;
  localparam int DEPTH_DEF = 256;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [KIND_W-1:0] KIND_ENQ  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEQ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SRCH = 2'd2;

endpackage

### rtl/cqs_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module cqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/circular_queue_with_search_top.sv
// Top level of the circular queue with search: sequencer, pointers and result registers.
//
// Usage: an operation beat is taken on a rising edge where start is high and busy is
// low. kind selects enqueue, dequeue or search; word_value is the word to store or to
// look for. Each beat yields exactly one result beat: done is high for one cycle and
// status, data_out, slot_index, occupancy, is_empty and is_full are valid with it.
// The receiver cannot stall, so results must be captured in the done cycle.
// Enqueue and any failing or unused operation finish straight from idle; dequeue
// first reads the oldest entry in the dequeue state; search ends at the first match,
// which is the oldest matching entry, or once every stored entry has been compared.
// The search rate is set by the single RAM read port, which is walked one entry per
// cycle from oldest to newest. busy is high while an item is in flight; start is
// ignored then.
// cfg_wr_en/cfg_wr_data set the usable capacity (0 behaves as 1, values above DEPTH
// behave as DEPTH) and flush the queue; write it only while the block is idle.
// Reset (rst, synchronous) empties the queue and sets the capacity to 256. The slot
// memory is not cleared; a slot's word is never used before it has been written.
module circular_queue_with_search_top #(
  parameter int DEPTH = cqs_pkg::DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [cqs_pkg::KIND_W-1:0]        kind,
  input  logic signed [cqs_pkg::WORD_W-1:0] word_value,
  output logic                              done,
  output logic                              status,
  output logic signed [cqs_pkg::WORD_W-1:0] data_out,
  output logic [cqs_pkg::SLOT_W-1:0]        slot_index,
  output logic [cqs_pkg::CAP_W-1:0]         occupancy,
  output logic                              is_empty,
  output logic                              is_full,
  input  logic                              cfg_wr_en,
  input  logic [cqs_pkg::CAP_W-1:0]         cfg_wr_data
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CAP_W = cqs_pkg::CAP_W;

  // Largest effective capacity: the ring depth, or whatever the register can hold.
  localparam logic [CAP_W-1:0] CAP_LIMIT =
    (DEPTH < (1 << CAP_W)) ? CAP_W'(DEPTH) : {CAP_W{1'b1}};

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DEQ  = 2'd1;
  localparam logic [1:0] ST_SRCH = 2'd2;

  // Control state.
  logic [1:0]       state, state_next;
  logic [CAP_W-1:0] capacity;
  logic [CAP_W-1:0] head, head_next;
  logic [CAP_W-1:0] count, count_next;
  logic [CAP_W-1:0] scan_pos, scan_pos_next;
  logic [CAP_W-1:0] issued, issued_next;
  logic             rd_valid, rd_valid_next;
  logic [CAP_W-1:0] rd_pos, rd_pos_next;
  logic signed [cqs_pkg::WORD_W-1:0] key;

  // Datapath.
  logic [CAP_W-1:0]          eff_cap;
  logic [CAP_W:0]            tail_sum;
  logic [CAP_W-1:0]          tail;
  logic [CAP_W-1:0]          inc_in, inc_out;
  logic [CAP_W-1:0]          rd_ring_pos;
  logic                      ram_wr_en;
  logic [cqs_pkg::WORD_W-1:0] ram_rd_data;
  logic                      hit;

  logic                      fin;
  logic                      res_status;
  logic [cqs_pkg::WORD_W-1:0] res_data;
  logic [CAP_W-1:0]          res_slot;

  // Saturate the capacity register into the usable range.
  always_comb begin
    if (capacity == '0) begin
      eff_cap = CAP_W'(1);
    end else if (capacity > CAP_LIMIT) begin
      eff_cap = CAP_LIMIT;
    end else begin
      eff_cap = capacity;
    end
  end

  // Head plus count stays below twice the capacity, so one subtract wraps it.
  assign tail_sum = {1'b0, head} + {1'b0, count};
  always_comb begin
    if (tail_sum >= {1'b0, eff_cap}) begin
      tail = CAP_W'(tail_sum - {1'b0, eff_cap});
    end else begin
      tail = tail_sum[CAP_W-1:0];
    end
  end

  // The one ring-pointer incrementer, shared by dequeue and the search walk.
  assign inc_in  = (state == ST_SRCH) ? scan_pos : head;
  assign inc_out = (inc_in + CAP_W'(1) == eff_cap) ? '0 : inc_in + CAP_W'(1);

  // The single comparator used by the search walk.
  assign hit = rd_valid && (ram_rd_data == key);

  assign rd_ring_pos = (state == ST_SRCH) ? scan_pos : head;

  always_comb begin
    state_next    = state;
    head_next     = head;
    count_next    = count;
    scan_pos_next = scan_pos;
    issued_next   = issued;
    rd_valid_next = 1'b0;
    rd_pos_next   = rd_pos;
    ram_wr_en     = 1'b0;
    fin           = 1'b0;
    res_status    = 1'b1;
    res_data      = '0;
    res_slot      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (kind)
            cqs_pkg::KIND_ENQ: begin
              fin = 1'b1;
              if (count < eff_cap) begin
                ram_wr_en  = 1'b1;
                count_next = count + CAP_W'(1);
                res_status = 1'b0;
              end
            end
            cqs_pkg::KIND_DEQ: begin
              if (count != '0) begin
                state_next = ST_DEQ;
              end else begin
                fin = 1'b1;
              end
            end
            cqs_pkg::KIND_SRCH: begin
              if (count != '0) begin
                state_next    = ST_SRCH;
                scan_pos_next = head;
                issued_next   = '0;
              end else begin
                fin = 1'b1;
              end
            end
            default: begin
              fin = 1'b1;
            end
          endcase
        end
      end
      ST_DEQ: begin
        fin        = 1'b1;
        res_status = 1'b0;
        res_data   = ram_rd_data;
        count_next = count - CAP_W'(1);
        head_next  = inc_out;
        state_next = ST_IDLE;
      end
      ST_SRCH: begin
        if (issued != count) begin
          scan_pos_next = inc_out;
          issued_next   = issued + CAP_W'(1);
          rd_valid_next = 1'b1;
          rd_pos_next   = scan_pos;
        end
        if (hit) begin
          fin        = 1'b1;
          res_status = 1'b0;
          res_slot   = rd_pos;
          state_next = ST_IDLE;
        end else if (issued == count) begin
          fin        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      capacity <= cqs_pkg::CAP_RESET;
      head     <= '0;
      count    <= '0;
      scan_pos <= '0;
      issued   <= '0;
      rd_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      scan_pos <= scan_pos_next;
      issued   <= issued_next;
      rd_valid <= rd_valid_next;
      done     <= fin;
      if (cfg_wr_en) begin
        // A capacity write flushes the queue; stored words become unreachable.
        capacity <= cfg_wr_data;
        head     <= '0;
        count    <= '0;
      end else begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    rd_pos <= rd_pos_next;
    if (start && !busy) begin
      key <= word_value;
    end
    if (fin) begin
      status     <= res_status;
      data_out   <= res_data;
      slot_index <= res_slot[cqs_pkg::SLOT_W-1:0];
      occupancy  <= count_next;
      is_empty   <= (count_next == '0);
      is_full    <= (count_next == eff_cap);
    end
  end

  assign busy = (state != ST_IDLE);

  cqs_ram #(
    .WIDTH (cqs_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (AW'(tail)),
    .wr_data (word_value),
    .rd_addr (AW'(rd_ring_pos)),
    .rd_data (ram_rd_data)
  );

`ifndef SYNTHESIS
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    count <= eff_cap)
    else $error("entry count exceeds capacity");

  a_head_in_range: assert property (@(posedge clk) disable iff (rst)
    head < eff_cap)
    else $error("head pointer beyond capacity");

  a_scan_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH) |-> (issued <= count))
    else $error("search walked past the newest entry");

  a_deq_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DEQ) |=> (done && !status))
    else $error("dequeue did not report success");

  a_cfg_flush: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en |=> (count == '0 && head == '0))
    else $error("capacity write did not flush the queue");
`endif

endmodule
